FILE: hdl/lsc_pkg.sv
// Shared types and constants for the Laplacian sharpen/clamp unit.
// No dependencies; used by lsc_result_fifo and laplacian_sharpen_clamp_unit.
`timescale 1ns / 1ps

package lsc_pkg;

    // Port field widths
    localparam int PIXEL_IN_BITS  = 8;
    localparam int TDATA_IN_BITS  = 8;
    localparam int OUT_BITS       = 10;
    localparam int TDATA_OUT_BITS = 16;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;

    // Frame geometry
    localparam int HEIGHT_BITS  = 11;
    localparam int ROW_BITS     = 10;
    localparam int MIN_SIZE     = 3;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int RESET_SIZE   = 10;

    // Arithmetic: wide enough for four 16-bit pixels
    localparam int ACC_BITS  = 18;
    localparam int OUT_LIMIT = 1023;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // One result item
    typedef struct packed {
        logic                end_of_frame;
        logic                last_in_run;
        logic [OUT_BITS-1:0] sharpened;
    } lsc_result_t;

    // Results produced by one pixel transfer: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0]  count;
        lsc_result_t second;
        lsc_result_t first;
    } lsc_push_t;

endpackage

FILE: hdl/lsc_result_fifo.sv
// Four-entry result queue between the filter datapath and the output stream.
// Takes up to two results per cycle, gives one per transfer. Depends on lsc_pkg.
`timescale 1ns / 1ps

module lsc_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  lsc_pkg::lsc_push_t  push,
    output logic                room_for_two,
    output logic                head_valid,
    input  logic                head_ready,
    output lsc_pkg::lsc_result_t head
);
    import lsc_pkg::*;

    lsc_result_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0]  count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0]  wr_ptr_plus1;
    logic                      pop;

    // Handshake status
    assign head_valid   = (count_reg != '0);
    assign room_for_two = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = head_valid && head_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_BITS'(1);

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_BITS'(push.count)
                      - (pop ? FIFO_CNT_BITS'(1) : FIFO_CNT_BITS'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

FILE: hdl/laplacian_sharpen_clamp_unit.sv
// Top level of the streaming 4-neighbour Laplacian, clamped to 0..1023.
// Depends on lsc_pkg and lsc_result_fifo.
`timescale 1ns / 1ps

// Takes a frame in raster order, one pixel per s_axis transfer, and gives
// 4*centre - up - down - left - right for the pixel one row above, negative
// values clamped to zero, values above 1023 to 1023, border pixels forced to
// zero. Row 0 pixels give no result; pixels of other rows give one; pixels of
// the last row give two (the row above, then the zero of the last row itself).
// One pixel is taken per clock while the result queue has room for two, and
// results leave at one per clock while m_tready is high, so in the last row
// the input is held back by the single output port. Both previous rows live
// in one line memory (one read and one write per pixel, the read running two
// columns ahead), so nothing is cleared after reset. Writing either
// configuration register restarts the frame at row 0, column 0; widths
// saturate to 3..MAX_WIDTH and heights to 3..1024.
module laplacian_sharpen_clamp_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Pixel stream in; s_tdata: [7:0] pixel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lsc_pkg::TDATA_IN_BITS-1:0]     s_tdata,
    // Result stream out; m_tdata: [9:0] sharpened, rest zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lsc_pkg::TDATA_OUT_BITS-1:0]    m_tdata,
    output logic                                  m_tlast,
    // m_tuser: [0] end_of_frame
    output logic                                  m_tuser,
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lsc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import lsc_pkg::*;

    localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WBITS       = $clog2(MAX_WIDTH + 1);
    localparam int SUM_BITS    = COL_BITS + 2;
    localparam int RESET_WIDTH = (MAX_WIDTH < RESET_SIZE) ? MAX_WIDTH : RESET_SIZE;

    // Geometry and position
    logic [WBITS-1:0]       width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [COL_BITS-1:0]    col_reg;
    logic [ROW_BITS-1:0]    row_reg;
    logic [HEIGHT_BITS-1:0] height_m1;

    // Line memory: upper half older row, lower half newer row
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] rd_data_reg;

    // Window around the current column (payload, no reset)
    logic [PIXEL_BITS-1:0] centre_reg;
    logic [PIXEL_BITS-1:0] up_reg;
    logic [PIXEL_BITS-1:0] left_reg;

    logic                  accept;
    logic [15:0]           pixel_ext;
    logic [PIXEL_BITS-1:0] px;
    logic [PIXEL_BITS-1:0] right_px;
    logic [SUM_BITS-1:0]   col_plus1;
    logic [SUM_BITS-1:0]   col_plus2;
    logic [SUM_BITS-1:0]   width_ext;
    logic [SUM_BITS-1:0]   ahead_sum;
    logic [COL_BITS-1:0]   ahead_addr;
    logic                  col_last;
    logic                  row_last;
    logic                  border;
    logic [ACC_BITS-1:0]   pos_sum;
    logic [ACC_BITS-1:0]   neg_sum;
    logic [ACC_BITS-1:0]   diff;
    logic [OUT_BITS-1:0]   value;
    lsc_push_t             push;
    lsc_result_t           head;
    logic                  room_for_two;

    assign cfg_ready = 1'b1;
    assign s_tready  = room_for_two;
    assign accept    = s_tvalid && s_tready;

    assign pixel_ext = 16'(s_tdata);
    assign px        = pixel_ext[PIXEL_BITS-1:0];
    assign right_px  = rd_data_reg[PIXEL_BITS-1:0];

    // Column bookkeeping and read-ahead address (two columns on, wrapping)
    always_comb
    begin
        height_m1  = height_reg - HEIGHT_BITS'(1);
        col_plus1  = SUM_BITS'(col_reg) + SUM_BITS'(1);
        col_plus2  = SUM_BITS'(col_reg) + SUM_BITS'(2);
        width_ext  = SUM_BITS'(width_reg);
        col_last   = (col_plus1 == width_ext);
        row_last   = (row_reg == height_m1[ROW_BITS-1:0]);
        ahead_sum  = (col_plus2 >= width_ext) ? col_plus2 - width_ext : col_plus2;
        ahead_addr = ahead_sum[COL_BITS-1:0];
    end

    // Laplacian with clamp below zero and above the output range
    always_comb
    begin
        border  = (row_reg == ROW_BITS'(1)) || (col_reg == '0) || col_last;
        pos_sum = ACC_BITS'(centre_reg) << 2;
        neg_sum = ACC_BITS'(up_reg) + ACC_BITS'(px) + ACC_BITS'(left_reg)
                  + ACC_BITS'(right_px);
        diff    = (pos_sum > neg_sum) ? pos_sum - neg_sum : '0;
        if (border)
        begin
            value = '0;
        end
        else if (diff > ACC_BITS'(OUT_LIMIT))
        begin
            value = OUT_BITS'(OUT_LIMIT);
        end
        else
        begin
            value = diff[OUT_BITS-1:0];
        end
    end

    // Results caused by this pixel
    always_comb
    begin
        push.first.sharpened     = value;
        push.first.last_in_run   = !row_last;
        push.first.end_of_frame  = 1'b0;
        push.second.sharpened    = '0;
        push.second.last_in_run  = 1'b1;
        push.second.end_of_frame = col_last;
        if (!accept || row_reg == '0)
        begin
            push.count = 2'd0;
        end
        else if (row_last)
        begin
            push.count = 2'd2;
        end
        else
        begin
            push.count = 2'd1;
        end
    end

    // Configuration and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WBITS'(RESET_WIDTH);
            height_reg <= HEIGHT_BITS'(RESET_SIZE);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_data < CFG_DATA_BITS'(MIN_SIZE))
                    begin
                        width_reg <= WBITS'(MIN_SIZE);
                    end
                    else if (32'(cfg_data) > MAX_WIDTH)
                    begin
                        width_reg <= WBITS'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_reg <= WBITS'(cfg_data);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data < CFG_DATA_BITS'(MIN_SIZE))
                    begin
                        height_reg <= HEIGHT_BITS'(MIN_SIZE);
                    end
                    else if (cfg_data > CFG_DATA_BITS'(HEIGHT_LIMIT))
                    begin
                        height_reg <= HEIGHT_BITS'(HEIGHT_LIMIT);
                    end
                    else
                    begin
                        height_reg <= cfg_data;
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
                default:
                begin
                    // unknown index: ignored
                end
            endcase
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_reg <= col_plus1[COL_BITS-1:0];
            end
        end
    end

    // Line memory: shift the column down one row, fetch two columns ahead
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= {centre_reg, px};
            rd_data_reg       <= line_mem[ahead_addr];
        end
    end

    // Slide the window one column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg   <= centre_reg;
            centre_reg <= rd_data_reg[PIXEL_BITS-1:0];
            up_reg     <= rd_data_reg[2*PIXEL_BITS-1:PIXEL_BITS];
        end
    end

    lsc_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .head_valid   (m_tvalid),
        .head_ready   (m_tready),
        .head         (head)
    );

    assign m_tdata = TDATA_OUT_BITS'(head.sharpened);
    assign m_tlast = head.last_in_run;
    assign m_tuser = head.end_of_frame;

endmodule
